### hw/rtl/rcca_pkg.sv
// Shared constants and codes for the refcount compacting allocator.
`timescale 1ns / 1ps

package rcca_pkg;

   localparam int POOL_BYTES_DEF  = 4096;
   localparam int MAX_OBJECTS_DEF = 64;
   localparam int ID_BITS_DEF     = 16;

   localparam int FUNC_W   = 2;
   localparam int SIZE_W   = 13;
   localparam int OBJID_W  = 16;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 12;
   localparam int COUNT_W  = 16;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT   = 2'd0,
      FN_RETRIEVE = 2'd1,
      FN_ADD_REF  = 2'd2,
      FN_DROP_REF = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_ROOM   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

### hw/rtl/rcca_if.sv
// Request and response channel interfaces of the allocator.
`timescale 1ns / 1ps

interface rcca_req_if;
   logic                        valid;
   logic                        ready;
   logic [rcca_pkg::FUNC_W-1:0]  func;
   logic [rcca_pkg::SIZE_W-1:0]  obj_size;
   logic [rcca_pkg::OBJID_W-1:0] obj_id;
   modport source (output valid, func, obj_size, obj_id, input ready);
   modport sink   (input valid, func, obj_size, obj_id, output ready);
endinterface

interface rcca_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rcca_pkg::STATUS_W-1:0] status;
   logic [rcca_pkg::OBJID_W-1:0]  new_id;
   logic [rcca_pkg::ADDR_W-1:0]   address;
   logic                          buffer_half;
   logic                          compacted;
   modport source (output valid, status, new_id, address, buffer_half, compacted,
                   input ready);
   modport sink   (input valid, status, new_id, address, buffer_half, compacted,
                   output ready);
endinterface

### hw/rtl/rcca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rcca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/refcount_compacting_allocator_unit.sv
// Top level of the refcount compacting allocator.
`timescale 1ns / 1ps

// The unit keeps an ordered table of up to MAX_OBJECTS objects in a pool of
// POOL_BYTES bytes, in one RAM with a registered read port. Insert appends at
// the free offset; if the object does not fit or the table is full, a
// compaction pass first walks the table once, dropping entries with a zero
// count and repacking the rest from offset 0, and a second fit check follows.
// Retrieve, add and drop walk the table from entry 0 one entry per cycle
// through the RAM read port and stop at the first match. One request is
// worked on at a time: req ready is high only while the unit is idle, and a
// finished result sits in the response register so a new request can be
// taken while it waits. No clearing pass is needed after reset.
module refcount_compacting_allocator_unit #(
   parameter int POOL_BYTES  = rcca_pkg::POOL_BYTES_DEF,
   parameter int MAX_OBJECTS = rcca_pkg::MAX_OBJECTS_DEF,
   parameter int ID_BITS     = rcca_pkg::ID_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   rcca_req_if.sink   req_if,
   rcca_rsp_if.source rsp_if
);

   localparam int OFF_BITS = $clog2(POOL_BYTES + 1);
   localparam int IDX_BITS = $clog2(MAX_OBJECTS);
   localparam int CNT_BITS = $clog2(MAX_OBJECTS + 1);
   localparam int CW       = rcca_pkg::COUNT_W;
   localparam int ENTRY_W  = ID_BITS + 2 * OFF_BITS + CW;

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_INSERT  = 5'b00010,
      S_COMPACT = 5'b00100,
      S_SCAN    = 5'b01000,
      S_FINISH  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // bookkeeping registers
   logic [CNT_BITS-1:0] total_ff, total_in;
   logic [OFF_BITS-1:0] free_ff, free_in;
   logic [ID_BITS-1:0]  next_id_ff, next_id_in;
   logic                half_ff, half_in;

   // walk pointers for lookup and compaction
   logic [CNT_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_BITS-1:0] pend_idx_ff, pend_idx_in;
   logic                pend_ff, pend_in;
   logic [OFF_BITS-1:0] pos_ff, pos_in;

   // latched request and result
   logic [rcca_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [rcca_pkg::SIZE_W-1:0]   size_ff, size_in;
   logic [rcca_pkg::OBJID_W-1:0]  objid_ff, objid_in;
   logic [rcca_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [rcca_pkg::OBJID_W-1:0]  res_id_ff, res_id_in;
   logic [rcca_pkg::ADDR_W-1:0]   res_addr_ff, res_addr_in;
   logic                          comp_ff, comp_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rcca_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [rcca_pkg::OBJID_W-1:0]  rsp_id_ff;
   logic [rcca_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic                          rsp_half_ff, rsp_comp_ff;
   logic                          rsp_load;

   // RAM port
   logic                we;
   logic [IDX_BITS-1:0] waddr, raddr;
   logic [ENTRY_W-1:0]  wdata, rdata;

   // fields of the entry read back
   logic [ID_BITS-1:0]  rd_id;
   logic [OFF_BITS-1:0] rd_off, rd_size;
   logic [CW-1:0]       rd_count;
   logic [31:0]         rd_id_wide, rd_off_wide, next_id_wide, free_wide;
   logic [31:0]         fit_sum;
   logic                fits, room, id_match;
   logic [ID_BITS-1:0]  id_inc;
   logic [CW-1:0]       cnt_mod;

   assign rd_count = rdata[CW-1:0];
   assign rd_size  = rdata[CW +: OFF_BITS];
   assign rd_off   = rdata[CW + OFF_BITS +: OFF_BITS];
   assign rd_id    = rdata[ENTRY_W-1 -: ID_BITS];

   assign rd_id_wide   = 32'(rd_id);
   assign rd_off_wide  = 32'(rd_off);
   assign next_id_wide = 32'(next_id_ff);
   assign free_wide    = 32'(free_ff);
   assign fit_sum      = 32'(size_ff) + free_wide;
   assign fits         = fit_sum <= 32'(POOL_BYTES);
   assign room         = total_ff < CNT_BITS'(MAX_OBJECTS);
   assign id_match     = pend_ff && (rd_id_wide[15:0] == objid_ff);
   assign id_inc       = next_id_ff + ID_BITS'(1);

   // saturate add at the top, hold drop at zero
   always_comb begin
      cnt_mod = rd_count;
      if (func_ff == rcca_pkg::FN_ADD_REF) begin
         if (rd_count != {CW{1'b1}}) cnt_mod = rd_count + CW'(1);
      end else if (rd_count != '0) begin
         cnt_mod = rd_count - CW'(1);
      end
   end

   assign raddr    = rd_ptr_ff[IDX_BITS-1:0];
   assign rsp_load = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      free_in       = free_ff;
      next_id_in    = next_id_ff;
      half_in       = half_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      pend_idx_in   = pend_idx_ff;
      pend_in       = 1'b0;
      pos_in        = pos_ff;
      func_in       = func_ff;
      size_in       = size_ff;
      objid_in      = objid_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_addr_in   = res_addr_ff;
      comp_in       = comp_ff;
      we            = 1'b0;
      waddr         = total_ff[IDX_BITS-1:0];
      wdata         = {next_id_ff, free_ff, OFF_BITS'(size_ff), CW'(1)};

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               func_in       = req_if.func;
               size_in       = req_if.obj_size;
               objid_in      = req_if.obj_id;
               res_status_in = rcca_pkg::ST_OK;
               res_id_in     = '0;
               res_addr_in   = '0;
               comp_in       = 1'b0;
               rd_ptr_in     = '0;
               wr_ptr_in     = '0;
               pos_in        = '0;
               state_in      = (req_if.func == rcca_pkg::FN_INSERT) ? S_INSERT : S_SCAN;
            end
         end
         S_INSERT: begin
            if (fits && room) begin
               // append at the free offset and hand out the id
               we          = 1'b1;
               total_in    = total_ff + CNT_BITS'(1);
               free_in     = OFF_BITS'(fit_sum);
               res_id_in   = next_id_wide[15:0];
               res_addr_in = free_wide[rcca_pkg::ADDR_W-1:0];
               next_id_in  = (id_inc == '0) ? ID_BITS'(1) : id_inc;
               state_in    = S_FINISH;
            end else if (!comp_ff) begin
               comp_in  = 1'b1;
               state_in = S_COMPACT;
            end else begin
               res_status_in = fits ? rcca_pkg::ST_FULL : rcca_pkg::ST_NO_ROOM;
               state_in      = S_FINISH;
            end
         end
         S_COMPACT: begin
            // keep live entries, moving them down to the write pointer
            if (pend_ff && rd_count != '0) begin
               we        = 1'b1;
               waddr     = wr_ptr_ff[IDX_BITS-1:0];
               wdata     = {rd_id, pos_ff, rd_size, rd_count};
               wr_ptr_in = wr_ptr_ff + CNT_BITS'(1);
               pos_in    = pos_ff + rd_size;
            end
            if (rd_ptr_ff < total_ff) begin
               rd_ptr_in = rd_ptr_ff + CNT_BITS'(1);
               pend_in   = 1'b1;
            end else if (!pend_ff) begin
               total_in = wr_ptr_ff;
               free_in  = pos_ff;
               half_in  = ~half_ff;
               state_in = S_INSERT;
            end
         end
         S_SCAN: begin
            if (objid_ff != '0 && id_match) begin
               if (func_ff == rcca_pkg::FN_RETRIEVE) begin
                  res_addr_in = rd_off_wide[rcca_pkg::ADDR_W-1:0];
               end else begin
                  we    = 1'b1;
                  waddr = pend_idx_ff;
                  wdata = {rdata[ENTRY_W-1:CW], cnt_mod};
               end
               state_in = S_FINISH;
            end else if (objid_ff != '0 && rd_ptr_ff < total_ff) begin
               rd_ptr_in   = rd_ptr_ff + CNT_BITS'(1);
               pend_idx_in = rd_ptr_ff[IDX_BITS-1:0];
               pend_in     = 1'b1;
            end else begin
               res_status_in = rcca_pkg::ST_NOT_FOUND;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold the response until the sink takes the beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_if.ready) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         free_ff      <= '0;
         next_id_ff   <= ID_BITS'(1);
         half_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         next_id_ff   <= next_id_in;
         half_ff      <= half_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      pend_idx_ff   <= pend_idx_in;
      pos_ff        <= pos_in;
      func_ff       <= func_in;
      size_ff       <= size_in;
      objid_ff      <= objid_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_addr_ff   <= res_addr_in;
      comp_ff       <= comp_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_half_ff   <= half_ff;
         rsp_comp_ff   <= comp_ff;
      end
   end

   rcca_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_OBJECTS)
   ) u_table (
      .clock(clock),
      .we(we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rdata)
   );

   assign req_if.ready       = (state_ff == S_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.new_id      = rsp_id_ff;
   assign rsp_if.address     = rsp_addr_ff;
   assign rsp_if.buffer_half = rsp_half_ff;
   assign rsp_if.compacted   = rsp_comp_ff;

endmodule

### hw/rtl/rcca_checker.sv
// Port-level assertions for the allocator and their bind.
`timescale 1ns / 1ps

module rcca_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rcca_pkg::STATUS_W-1:0] rsp_status,
   input logic [rcca_pkg::OBJID_W-1:0]  rsp_new_id,
   input logic [rcca_pkg::ADDR_W-1:0]   rsp_address,
   input logic                          rsp_compacted
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
      else $error("stalled response dropped or changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rcca_pkg::ST_OK) |->
      (rsp_new_id == '0 && rsp_address == '0))
      else $error("failed step reports an id or address");

   a_compact_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compacted) |-> (rsp_status != rcca_pkg::ST_NOT_FOUND))
      else $error("compaction outside an insert");

endmodule

bind refcount_compacting_allocator_unit rcca_checker u_rcca_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_if.valid),
   .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid),
   .rsp_ready(rsp_if.ready),
   .rsp_status(rsp_if.status),
   .rsp_new_id(rsp_if.new_id),
   .rsp_address(rsp_if.address),
   .rsp_compacted(rsp_if.compacted)
);

### verif/refcount_compacting_allocator_unit_tb.sv
// Self-checking testbench for the refcount compacting allocator unit.
`timescale 1ns / 1ps

module testbench;
   import rcca_pkg::*;

   localparam int POOL  = POOL_BYTES_DEF;
   localparam int SLOTS = MAX_OBJECTS_DEF;
   localparam int LIMIT_CYCLES = 1000000;

   typedef struct packed {
      status_type           status;
      logic [OBJID_W-1:0]   new_id;
      logic [ADDR_W-1:0]    address;
      logic                 buffer_half;
      logic                 compacted;
   } outcome_t;

   typedef struct {
      logic [15:0] id;
      int          off;
      int          size;
      int          count;
   } object_t;

   // Tracks the object table and holds outcomes waiting for their beat.
   class alloc_scoreboard;
      object_t  objects[SLOTS];
      int       used;
      int       free_off;
      int       next_id;
      bit       half;
      outcome_t pending[$];
      int       mismatches;
      int       checked;

      function new();
         used = 0;
         free_off = 0;
         next_id = 1;
         half = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function int lookup(logic [15:0] id);
         if (id == 0) return -1;
         for (int i = 0; i < used; i++)
            if (objects[i].id == id) return i;
         return -1;
      endfunction

      function void repack();
         int wr;
         int pos;
         wr = 0;
         pos = 0;
         for (int rd = 0; rd < used; rd++)
            if (objects[rd].count != 0) begin
               objects[wr] = objects[rd];
               objects[wr].off = pos;
               pos += objects[rd].size;
               wr++;
            end
         used = wr;
         free_off = pos;
         half = ~half;
      endfunction

      function void note_request(func_type fn, logic [SIZE_W-1:0] size, logic [15:0] id);
         outcome_t o;
         int k;
         o = '0;
         o.status = ST_OK;
         if (fn == FN_INSERT) begin
            if (int'(size) + free_off > POOL || used >= SLOTS) begin
               repack();
               o.compacted = 1;
            end
            if (int'(size) + free_off > POOL) o.status = ST_NO_ROOM;
            else if (used >= SLOTS) o.status = ST_FULL;
            else begin
               objects[used].id = next_id[15:0];
               objects[used].off = free_off;
               objects[used].size = size;
               objects[used].count = 1;
               used++;
               o.new_id = next_id[15:0];
               o.address = free_off[ADDR_W-1:0];
               free_off += size;
               next_id = (next_id + 1) & 16'hFFFF;
               if (next_id == 0) next_id = 1;
            end
         end else begin
            k = lookup(id);
            if (k < 0) o.status = ST_NOT_FOUND;
            else if (fn == FN_RETRIEVE) o.address = objects[k].off[ADDR_W-1:0];
            else if (fn == FN_ADD_REF) begin
               if (objects[k].count < 16'hFFFF) objects[k].count++;
            end else if (objects[k].count > 0) objects[k].count--;
         end
         o.buffer_half = half;
         pending.push_back(o);
      endfunction

      function void check_beat(outcome_t got);
         outcome_t want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   rcca_req_if req_if ();
   rcca_rsp_if rsp_if ();
   alloc_scoreboard board;
   int  cycle = 0;
   int  sent = 0;
   bit  quiet = 0;

   refcount_compacting_allocator_unit dut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_if.valid = 0;
      req_if.func = FN_INSERT;
      req_if.obj_size = 0;
      req_if.obj_id = 0;
      rsp_if.ready = 0;
      board = new();
   end

   // Watch the edge: count cycles, note accepted requests, check result beats.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset) begin
         if (req_if.valid && req_if.ready)
            board.note_request(func_type'(req_if.func), req_if.obj_size, req_if.obj_id);
         if (rsp_if.valid && rsp_if.ready)
            board.check_beat({status_type'(rsp_if.status), rsp_if.new_id,
                              rsp_if.address, rsp_if.buffer_half, rsp_if.compacted});
      end
   end

   // Random response stall, absent during the quiet stretch.
   always @(negedge clock)
      rsp_if.ready <= reset ? 1'b0 : (quiet || $urandom_range(99) >= 9);

   // Drive one request beat and hold it until the unit takes it.
   task automatic send_req(func_type fn, int size, int id);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 9) begin
         req_if.valid <= 0;
         @(negedge clock);
      end
      req_if.valid <= 1;
      req_if.func <= fn;
      req_if.obj_size <= size[SIZE_W-1:0];
      req_if.obj_id <= id[15:0];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent++;
      @(negedge clock);
      req_if.valid <= 0;
   endtask

   // Pick an id that is likely live, sometimes a random or null one.
   function automatic int pick_id();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 0;
      if (r < 10 || board.used == 0) return $urandom_range(16'hFFFF);
      return board.objects[$urandom_range(board.used - 1)].id;
   endfunction

   task automatic random_req();
      int r;
      int size;
      r = $urandom_range(99);
      if (r < 35) begin
         r = $urandom_range(99);
         if (r < 70) size = $urandom_range(120);
         else if (r < 90) size = $urandom_range(4096);
         else if (r < 95) size = 0;
         else size = $urandom_range(8191);
         send_req(FN_INSERT, size, $urandom_range(16'hFFFF));
      end else if (r < 55) send_req(FN_RETRIEVE, $urandom_range(8191), pick_id());
      else if (r < 72) send_req(FN_ADD_REF, $urandom_range(8191), pick_id());
      else send_req(FN_DROP_REF, $urandom_range(8191), pick_id());
   endtask

   initial begin
      int guard;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: fields at their extremes, each function, dead entries, full table.
      send_req(FN_RETRIEVE, 0, 0);
      send_req(FN_RETRIEVE, 8191, 16'hFFFF);
      send_req(FN_INSERT, 0, 0);
      send_req(FN_INSERT, 4096, 16'hFFFF);
      send_req(FN_INSERT, 8191, 0);
      send_req(FN_INSERT, 100, 0);
      send_req(FN_RETRIEVE, 0, 3);
      send_req(FN_ADD_REF, 0, 3);
      send_req(FN_DROP_REF, 0, 3);
      send_req(FN_DROP_REF, 0, 3);
      send_req(FN_DROP_REF, 0, 3);
      send_req(FN_RETRIEVE, 0, 3);
      send_req(FN_ADD_REF, 0, 3);
      send_req(FN_DROP_REF, 0, 2);
      send_req(FN_INSERT, 4000, 0);
      send_req(FN_DROP_REF, 0, 0);
      send_req(FN_ADD_REF, 0, 16'hFFFF);
      for (int i = 0; i < 66; i++) send_req(FN_INSERT, i % 2, 0);
      send_req(FN_INSERT, 4096, 0);

      // Random: 800 requests under stalls, then a quiet stretch of 200, then stalls again.
      for (int i = 0; i < 1850; i++) begin
         quiet = (i >= 800 && i < 1000);
         random_req();
      end
      quiet = 0;

      guard = 0;
      while (board.pending.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
      $display("ran %0d requests, %0d result beats checked, %0d mismatches",
               sent, board.checked, board.mismatches);
      $display("covered inserts with compaction, lookups, reference adds and drops");
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

### sim.f
hw/rtl/rcca_pkg.sv
hw/rtl/rcca_if.sv
hw/rtl/rcca_ram.sv
hw/rtl/refcount_compacting_allocator_unit.sv
hw/rtl/rcca_checker.sv
verif/refcount_compacting_allocator_unit_tb.sv
